FILE: hdl/pys_pkg.sv
// Shared types and constants for the periodic Yee field stepper.
`timescale 1ns / 1ps
`default_nettype none
package pys_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_STEP  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam int FIELD_W    = 32;
	localparam int COEF_W     = 18;
	localparam int CELL_W     = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int NUM_FIELDS = 6;
	localparam int NUM_COEF   = 8;
	localparam int FSEL_W     = 3;

	// field order in every array of six
	localparam int F_EX = 0;
	localparam int F_EY = 1;
	localparam int F_EZ = 2;
	localparam int F_HX = 3;
	localparam int F_HY = 4;
	localparam int F_HZ = 5;

	// coefficient register indexes
	localparam int C_E_DECAY  = 0;
	localparam int C_E_GAIN_X = 1;
	localparam int C_E_GAIN_Y = 2;
	localparam int C_E_GAIN_Z = 3;
	localparam int C_H_DECAY  = 4;
	localparam int C_H_GAIN_X = 5;
	localparam int C_H_GAIN_Y = 6;
	localparam int C_H_GAIN_Z = 7;

	localparam logic signed [COEF_W-1:0] COEF_RESET = 18'sd65536;

	typedef logic signed [FIELD_W-1:0] field_t;
	typedef logic signed [COEF_W-1:0]  coef_t;

	// component index within a sweep
	localparam logic [1:0] COMP_X = 2'd0;
	localparam logic [1:0] COMP_Y = 2'd1;
	localparam logic [1:0] COMP_Z = 2'd2;

	typedef struct packed {
		logic       clr_we;
		logic       host_we;
		logic       lat_own;
		logic       lat_x;
		logic       lat_y;
		logic       lat_z;
		logic       mul_go;
		logic [1:0] comp;
		logic       h_phase;
		logic       sat_clr;
		logic       out_ld_zero;
		logic       out_ld_read;
		logic       out_ld_step;
	} ctl_t;

endpackage
`default_nettype wire

FILE: hdl/pys_if.sv
// Input and output channel interfaces of the field stepper.
`timescale 1ns / 1ps
`default_nettype none
interface pys_in_if;
	logic                    valid;
	logic                    ready;
	logic [1:0]              cmd;
	logic [3:0]              cell_x;
	logic [3:0]              cell_y;
	logic [3:0]              cell_z;
	pys_pkg::field_t         in_ex;
	pys_pkg::field_t         in_ey;
	pys_pkg::field_t         in_ez;
	pys_pkg::field_t         in_hx;
	pys_pkg::field_t         in_hy;
	pys_pkg::field_t         in_hz;

	modport source (output valid, cmd, cell_x, cell_y, cell_z,
		in_ex, in_ey, in_ez, in_hx, in_hy, in_hz, input ready);
	modport sink (input valid, cmd, cell_x, cell_y, cell_z,
		in_ex, in_ey, in_ez, in_hx, in_hy, in_hz, output ready);
endinterface

interface pys_out_if;
	logic            valid;
	logic            ready;
	pys_pkg::field_t out_ex;
	pys_pkg::field_t out_ey;
	pys_pkg::field_t out_ez;
	pys_pkg::field_t out_hx;
	pys_pkg::field_t out_hy;
	pys_pkg::field_t out_hz;
	logic            saturated;

	modport source (output valid, out_ex, out_ey, out_ez, out_hx, out_hy, out_hz,
		saturated, input ready);
	modport sink (input valid, out_ex, out_ey, out_ez, out_hx, out_hy, out_hz,
		saturated, output ready);
endinterface
`default_nettype wire

FILE: hdl/pys_ctrl.sv
// Command sequencer: clearing pass, host access and the two-sweep time step.
`timescale 1ns / 1ps
`default_nettype none
module pys_ctrl #(
	parameter int GRID_SIDE = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [1:0]            in_cmd,
	input  wire logic [3:0]            cell_x,
	input  wire logic [3:0]            cell_y,
	input  wire logic [3:0]            cell_z,
	input  wire logic                  out_ready,
	output logic                       in_ready,
	output logic                       out_valid,
	output pys_pkg::ctl_t              ctl,
	output logic [3*$clog2(GRID_SIDE)-1:0] a_addr,
	output logic [3*$clog2(GRID_SIDE)-1:0] b_addr
);
	localparam int AW = $clog2(GRID_SIDE);
	localparam logic [AW-1:0] LAST = AW'(GRID_SIDE - 1);
	localparam logic [8:0] SIDE = 9'(GRID_SIDE);

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_RD, ST_R0, ST_R1, ST_R2, ST_LT,
		ST_M0, ST_M1, ST_M2, ST_D1, ST_D2, ST_FIN
	} state_t;

	state_t state_q;
	logic [AW-1:0] x_q, y_q, z_q;
	logic h_q, in_grid_q, out_valid_q;

	logic accept, in_grid, last_cell;
	logic [AW-1:0] nx, ny, nz, x_n, y_n, z_n;

	always_comb begin
		in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
		accept    = in_valid && in_ready;
		in_grid   = (9'(cell_x) < SIDE) && (9'(cell_y) < SIDE) && (9'(cell_z) < SIDE);
		out_valid = out_valid_q;
		last_cell = (x_q == LAST) && (y_q == LAST) && (z_q == LAST);
		// E sweep looks one cell up, H sweep one cell down, wrapping
		if (h_q) begin
			nx = (x_q == '0) ? LAST : x_q - 1'b1;
			ny = (y_q == '0) ? LAST : y_q - 1'b1;
			nz = (z_q == '0) ? LAST : z_q - 1'b1;
		end else begin
			nx = (x_q == LAST) ? '0 : x_q + 1'b1;
			ny = (y_q == LAST) ? '0 : y_q + 1'b1;
			nz = (z_q == LAST) ? '0 : z_q + 1'b1;
		end
		z_n = (z_q == LAST) ? '0 : z_q + 1'b1;
		y_n = y_q;
		x_n = x_q;
		if (z_q == LAST) begin
			y_n = (y_q == LAST) ? '0 : y_q + 1'b1;
			if (y_q == LAST) begin
				x_n = (x_q == LAST) ? '0 : x_q + 1'b1;
			end
		end
		if (state_q == ST_IDLE) begin
			a_addr = {AW'(cell_x), AW'(cell_y), AW'(cell_z)};
		end else begin
			a_addr = {x_q, y_q, z_q};
		end
		unique case (state_q)
			ST_R1:   b_addr = {x_q, ny, z_q};
			ST_R2:   b_addr = {x_q, y_q, nz};
			default: b_addr = {nx, y_q, z_q};
		endcase

		ctl         = '0;
		ctl.h_phase = h_q;
		unique case (state_q)
			ST_CLR:  ctl.clr_we = 1'b1;
			ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						pys_pkg::CMD_WRITE: begin
							ctl.host_we     = in_grid;
							ctl.out_ld_zero = 1'b1;
						end
						pys_pkg::CMD_READ:  ;
						pys_pkg::CMD_STEP:  ctl.sat_clr = 1'b1;
						default:            ctl.out_ld_zero = 1'b1;
					endcase
				end
			end
			ST_RD: begin
				ctl.out_ld_read = in_grid_q;
				ctl.out_ld_zero = !in_grid_q;
			end
			ST_R1: begin
				ctl.lat_own = 1'b1;
				ctl.lat_x   = 1'b1;
			end
			ST_R2: ctl.lat_y = 1'b1;
			ST_LT: ctl.lat_z = 1'b1;
			ST_M0: begin
				ctl.mul_go = 1'b1;
				ctl.comp   = pys_pkg::COMP_X;
			end
			ST_M1: begin
				ctl.mul_go = 1'b1;
				ctl.comp   = pys_pkg::COMP_Y;
			end
			ST_M2: begin
				ctl.mul_go = 1'b1;
				ctl.comp   = pys_pkg::COMP_Z;
			end
			ST_FIN: ctl.out_ld_step = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			x_q         <= '0;
			y_q         <= '0;
			z_q         <= '0;
			h_q         <= 1'b0;
			in_grid_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.out_ld_zero || ctl.out_ld_read || ctl.out_ld_step) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					x_q <= x_n;
					y_q <= y_n;
					z_q <= z_n;
					if (last_cell) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						in_grid_q <= in_grid;
						if (in_cmd == pys_pkg::CMD_READ) begin
							state_q <= ST_RD;
						end else if (in_cmd == pys_pkg::CMD_STEP) begin
							h_q     <= 1'b0;
							x_q     <= '0;
							y_q     <= '0;
							z_q     <= '0;
							state_q <= ST_R0;
						end
					end
				end
				ST_RD: state_q <= ST_IDLE;
				ST_R0: state_q <= ST_R1;
				ST_R1: state_q <= ST_R2;
				ST_R2: state_q <= ST_LT;
				ST_LT: state_q <= ST_M0;
				ST_M0: state_q <= ST_M1;
				ST_M1: state_q <= ST_M2;
				ST_M2: begin
					x_q     <= x_n;
					y_q     <= y_n;
					z_q     <= z_n;
					state_q <= last_cell ? ST_D1 : ST_R0;
				end
				ST_D1: state_q <= ST_D2;
				// let the last writes land before the next sweep reads
				ST_D2: begin
					if (!h_q) begin
						h_q     <= 1'b1;
						state_q <= ST_R0;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/pys_dp.sv
// Datapath: field memories, coefficient registers, shared update unit, result register.
`timescale 1ns / 1ps
`default_nettype none
module pys_dp #(
	parameter int GRID_SIDE = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pys_pkg::ctl_t                 ctl,
	input  wire logic [3*$clog2(GRID_SIDE)-1:0] a_addr,
	input  wire logic [3*$clog2(GRID_SIDE)-1:0] b_addr,
	input  wire logic                          cfg_we,
	input  wire logic [pys_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pys_pkg::COEF_W-1:0]    cfg_data,
	input  wire pys_pkg::field_t               wr_data [pys_pkg::NUM_FIELDS],
	output pys_pkg::field_t                    out_data [pys_pkg::NUM_FIELDS],
	output logic                               out_sat
);
	localparam int ADDR_W = 3 * $clog2(GRID_SIDE);
	localparam int MEM_DEPTH = 1 << ADDR_W;

	pys_pkg::coef_t  coef_q [pys_pkg::NUM_COEF];
	pys_pkg::field_t rda_q [pys_pkg::NUM_FIELDS];
	pys_pkg::field_t rdb_q [pys_pkg::NUM_FIELDS];
	pys_pkg::field_t own_q [pys_pkg::NUM_FIELDS];
	pys_pkg::field_t nx_q [pys_pkg::NUM_FIELDS];
	pys_pkg::field_t ny_q [pys_pkg::NUM_FIELDS];
	pys_pkg::field_t nz_q [pys_pkg::NUM_FIELDS];
	pys_pkg::field_t out_q [pys_pkg::NUM_FIELDS];
	logic out_sat_q, sat_q;

	pys_pkg::coef_t  op_self, op_g1, op_g2;
	pys_pkg::field_t op_old;
	logic signed [32:0] op_d1, op_d2;
	logic [pys_pkg::FSEL_W-1:0] fsel;

	logic                        v_s1, v_s2;
	logic signed [49:0]          p0_s1;
	logic signed [50:0]          p1_s1, p2_s1;
	logic [pys_pkg::FSEL_W-1:0]  f_s1, f_s2;
	logic [ADDR_W-1:0]           addr_s1, addr_s2;
	pys_pkg::field_t             res_s2;
	logic                        sat_s2;

	logic signed [52:0] acc;
	logic [36:0] rnd;
	logic ovf;
	pys_pkg::field_t res;

	function automatic logic signed [32:0] diff(input pys_pkg::field_t a,
		input pys_pkg::field_t b);
		return 33'(a) - 33'(b);
	endfunction

	// coefficient registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pys_pkg::NUM_COEF; i++) begin
				coef_q[i] <= pys_pkg::COEF_RESET;
			end
		end else if (cfg_we && (cfg_index < pys_pkg::CFG_IDX_W'(pys_pkg::NUM_COEF))) begin
			coef_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	// field memories: one write port, two registered read ports each
	for (genvar f = 0; f < pys_pkg::NUM_FIELDS; f++) begin : g_mem
		logic [pys_pkg::FIELD_W-1:0] mem [MEM_DEPTH];
		logic we;
		logic [ADDR_W-1:0] wa;
		pys_pkg::field_t wd;

		assign we = ctl.clr_we || ctl.host_we || (v_s2 && (f_s2 == pys_pkg::FSEL_W'(f)));
		assign wa = v_s2 ? addr_s2 : a_addr;
		assign wd = ctl.clr_we ? '0 : (ctl.host_we ? wr_data[f] : res_s2);

		always_ff @(posedge clk) begin
			if (we) begin
				mem[wa] <= wd;
			end
			rda_q[f] <= mem[a_addr];
			rdb_q[f] <= mem[b_addr];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < pys_pkg::NUM_FIELDS; i++) begin
			if (ctl.lat_own) own_q[i] <= rda_q[i];
			if (ctl.lat_x)   nx_q[i]  <= rdb_q[i];
			if (ctl.lat_y)   ny_q[i]  <= rdb_q[i];
			if (ctl.lat_z)   nz_q[i]  <= rdb_q[i];
		end
	end

	// operand select for one component of one sweep
	always_comb begin
		op_self = '0;
		op_old  = '0;
		op_g1   = '0;
		op_d1   = '0;
		op_g2   = '0;
		op_d2   = '0;
		case ({ctl.h_phase, ctl.comp})
			{1'b0, pys_pkg::COMP_X}: begin
				op_self = coef_q[pys_pkg::C_E_DECAY];
				op_old  = own_q[pys_pkg::F_EX];
				op_g1   = coef_q[pys_pkg::C_E_GAIN_Y];
				op_d1   = diff(ny_q[pys_pkg::F_HZ], own_q[pys_pkg::F_HZ]);
				op_g2   = coef_q[pys_pkg::C_E_GAIN_Z];
				op_d2   = diff(own_q[pys_pkg::F_HY], nz_q[pys_pkg::F_HY]);
			end
			{1'b0, pys_pkg::COMP_Y}: begin
				op_self = coef_q[pys_pkg::C_E_DECAY];
				op_old  = own_q[pys_pkg::F_EY];
				op_g1   = coef_q[pys_pkg::C_E_GAIN_X];
				op_d1   = diff(own_q[pys_pkg::F_HZ], nx_q[pys_pkg::F_HZ]);
				op_g2   = coef_q[pys_pkg::C_E_GAIN_Z];
				op_d2   = diff(nz_q[pys_pkg::F_HX], own_q[pys_pkg::F_HX]);
			end
			{1'b0, pys_pkg::COMP_Z}: begin
				op_self = coef_q[pys_pkg::C_E_DECAY];
				op_old  = own_q[pys_pkg::F_EZ];
				op_g1   = coef_q[pys_pkg::C_E_GAIN_X];
				op_d1   = diff(nx_q[pys_pkg::F_HY], own_q[pys_pkg::F_HY]);
				op_g2   = coef_q[pys_pkg::C_E_GAIN_Y];
				op_d2   = diff(own_q[pys_pkg::F_HX], ny_q[pys_pkg::F_HX]);
			end
			{1'b1, pys_pkg::COMP_X}: begin
				op_self = coef_q[pys_pkg::C_H_DECAY];
				op_old  = own_q[pys_pkg::F_HX];
				op_g1   = coef_q[pys_pkg::C_H_GAIN_Y];
				op_d1   = diff(ny_q[pys_pkg::F_EZ], own_q[pys_pkg::F_EZ]);
				op_g2   = coef_q[pys_pkg::C_H_GAIN_Z];
				op_d2   = diff(own_q[pys_pkg::F_EY], nz_q[pys_pkg::F_EY]);
			end
			{1'b1, pys_pkg::COMP_Y}: begin
				op_self = coef_q[pys_pkg::C_H_DECAY];
				op_old  = own_q[pys_pkg::F_HY];
				op_g1   = coef_q[pys_pkg::C_H_GAIN_X];
				op_d1   = diff(own_q[pys_pkg::F_EZ], nx_q[pys_pkg::F_EZ]);
				op_g2   = coef_q[pys_pkg::C_H_GAIN_Z];
				op_d2   = diff(nz_q[pys_pkg::F_EX], own_q[pys_pkg::F_EX]);
			end
			{1'b1, pys_pkg::COMP_Z}: begin
				op_self = coef_q[pys_pkg::C_H_DECAY];
				op_old  = own_q[pys_pkg::F_HZ];
				op_g1   = coef_q[pys_pkg::C_H_GAIN_X];
				op_d1   = diff(nx_q[pys_pkg::F_EY], own_q[pys_pkg::F_EY]);
				op_g2   = coef_q[pys_pkg::C_H_GAIN_Y];
				op_d2   = diff(own_q[pys_pkg::F_EX], ny_q[pys_pkg::F_EX]);
			end
			default: ;
		endcase
		fsel = ctl.h_phase ? pys_pkg::FSEL_W'(ctl.comp) + pys_pkg::FSEL_W'(pys_pkg::F_HX)
			: pys_pkg::FSEL_W'(ctl.comp);
	end

	// round half up to Q16.16, then clamp to 32 bits
	always_comb begin
		acc = 53'(p0_s1) + 53'(p1_s1) + 53'(p2_s1) + 53'sd32768;
		rnd = acc[52:16];
		ovf = !((&rnd[36:31]) || !(|rnd[36:31]));
		if (ovf) begin
			res = rnd[36] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			res = rnd[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.mul_go;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		p0_s1   <= op_self * op_old;
		p1_s1   <= op_g1 * op_d1;
		p2_s1   <= op_g2 * op_d2;
		f_s1    <= fsel;
		addr_s1 <= a_addr;
		res_s2  <= res;
		sat_s2  <= ovf;
		f_s2    <= f_s1;
		addr_s2 <= addr_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (ctl.sat_clr) begin
			sat_q <= 1'b0;
		end else if (v_s2 && sat_s2) begin
			sat_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_ld_zero || ctl.out_ld_step) begin
			for (int i = 0; i < pys_pkg::NUM_FIELDS; i++) begin
				out_q[i] <= '0;
			end
			out_sat_q <= ctl.out_ld_step && sat_q;
		end else if (ctl.out_ld_read) begin
			for (int i = 0; i < pys_pkg::NUM_FIELDS; i++) begin
				out_q[i] <= rda_q[i];
			end
			out_sat_q <= 1'b0;
		end
	end

	assign out_data = out_q;
	assign out_sat  = out_sat_q;

endmodule
`default_nettype wire

FILE: hdl/periodic_yee_field_stepper.sv
// Top level of the periodic Yee field stepper.
// Holds Ex, Ey, Ez, Hx, Hy, Hz on a GRID_SIDE^3 grid with periodic wrap. After reset the
// block clears all six grids, one cell a cycle, and accepts no word until that is done
// (coefficient writes are taken at any time). A write word stores a cell and returns an
// all-zero result word; a read word returns the cell through the read-port register and
// then the result register. A step word runs an E sweep and then an H sweep over every cell;
// the pace of each cell is set by the three neighbor reads per cell on the second read port
// of each field memory and by the single shared multiply-accumulate unit that computes the
// three components of a cell in turn. The step's result word carries only the saturation
// flag. A new word is accepted only while the output register is empty or its word is taken
// in the same cycle.
`timescale 1ns / 1ps
`default_nettype none
module periodic_yee_field_stepper #(
	parameter int GRID_SIDE = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pys_in_if.sink                             in_ch,
	pys_out_if.source                          out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [pys_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [pys_pkg::COEF_W-1:0]    cfg_data
);
	localparam int ADDR_W = 3 * $clog2(GRID_SIDE);

	pys_pkg::ctl_t   ctl;
	logic [ADDR_W-1:0] a_addr, b_addr;
	pys_pkg::field_t wr_data [pys_pkg::NUM_FIELDS];
	pys_pkg::field_t out_data [pys_pkg::NUM_FIELDS];

	assign wr_data[pys_pkg::F_EX] = in_ch.in_ex;
	assign wr_data[pys_pkg::F_EY] = in_ch.in_ey;
	assign wr_data[pys_pkg::F_EZ] = in_ch.in_ez;
	assign wr_data[pys_pkg::F_HX] = in_ch.in_hx;
	assign wr_data[pys_pkg::F_HY] = in_ch.in_hy;
	assign wr_data[pys_pkg::F_HZ] = in_ch.in_hz;

	pys_ctrl #(.GRID_SIDE(GRID_SIDE)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.cell_x    (in_ch.cell_x),
		.cell_y    (in_ch.cell_y),
		.cell_z    (in_ch.cell_z),
		.out_ready (out_ch.ready),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.ctl       (ctl),
		.a_addr    (a_addr),
		.b_addr    (b_addr)
	);

	pys_dp #(.GRID_SIDE(GRID_SIDE)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.a_addr    (a_addr),
		.b_addr    (b_addr),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.wr_data   (wr_data),
		.out_data  (out_data),
		.out_sat   (out_ch.saturated)
	);

	assign out_ch.out_ex = out_data[pys_pkg::F_EX];
	assign out_ch.out_ey = out_data[pys_pkg::F_EY];
	assign out_ch.out_ez = out_data[pys_pkg::F_EZ];
	assign out_ch.out_hx = out_data[pys_pkg::F_HX];
	assign out_ch.out_hy = out_data[pys_pkg::F_HY];
	assign out_ch.out_hz = out_data[pys_pkg::F_HZ];

endmodule
`default_nettype wire

FILE: hdl/pys_checker.sv
// Port-level checks for the field stepper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pys_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [1:0]  in_cmd,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] out_ex,
	input wire logic [31:0] out_hz,
	input wire logic        out_sat
);
	// a result word holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before it was taken");

	// no new word while an untaken result sits at the output
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("word accepted while output is blocked");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == pys_pkg::CMD_WRITE
		|=> out_valid && out_ex == '0 && out_hz == '0 && !out_sat)
		else $error("write word did not give an all-zero result");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_cmd == pys_pkg::CMD_READ |=> !in_ready)
		else $error("read word accepted back to back");

	a_sat_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sat |-> out_ex == '0 && out_hz == '0)
		else $error("saturation flag with nonzero fields");
endmodule

bind periodic_yee_field_stepper pys_checker u_pys_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_cmd    (in_ch.cmd),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_ex    (out_ch.out_ex),
	.out_hz    (out_ch.out_hz),
	.out_sat   (out_ch.saturated)
);
`default_nettype wire

FILE: dv/pys_tb_checker.sv
// Checker for the periodic Yee field stepper: predicts every result word and compares it.
`timescale 1ns / 1ps
`default_nettype none
module pys_tb_checker
	import pys_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	pys_in_if                         in_ch,
	pys_out_if                        out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COEF_W-1:0]    cfg_data,
	output int                        words_pending,
	output int                        fail_count
);
	localparam int CELLS = 4096;

	typedef struct {
		field_t f[NUM_FIELDS];
		logic   sat;
	} result_t;

	field_t  grid[NUM_FIELDS][CELLS];
	coef_t   coef[NUM_COEF];
	result_t expected_words[$];
	logic    step_sat;

	function automatic int cell_of(logic [3:0] x, logic [3:0] y, logic [3:0] z);
		return int'({x, y, z});
	endfunction

	// self*old + g1*d1 + g2*d2, rounded half up to Q16.16, saturated
	function automatic field_t mac3(coef_t self_c, field_t old, coef_t g1, longint d1,
		coef_t g2, longint d2);
		longint s;
		longint r;
		s = longint'(self_c) * longint'(old) + longint'(g1) * d1 + longint'(g2) * d2;
		r = (s + 32768) >>> 16;
		if (r > 64'sd2147483647) begin
			step_sat = 1'b1;
			return 32'sh7fff_ffff;
		end
		if (r < -64'sd2147483648) begin
			step_sat = 1'b1;
			return 32'sh8000_0000;
		end
		return field_t'(r);
	endfunction

	function automatic longint diff(field_t a, field_t b);
		return longint'(a) - longint'(b);
	endfunction

	task automatic advance_fields();
		logic [3:0] x, y, z;
		int c, px, py, pz, mx, my, mz;
		step_sat = 1'b0;
		for (int i = 0; i < CELLS; i++) begin
			{x, y, z} = i[11:0];
			c  = i;
			px = cell_of(x + 4'd1, y, z);
			py = cell_of(x, y + 4'd1, z);
			pz = cell_of(x, y, z + 4'd1);
			grid[F_EX][c] = mac3(coef[C_E_DECAY], grid[F_EX][c],
				coef[C_E_GAIN_Y], diff(grid[F_HZ][py], grid[F_HZ][c]),
				coef[C_E_GAIN_Z], diff(grid[F_HY][c], grid[F_HY][pz]));
			grid[F_EY][c] = mac3(coef[C_E_DECAY], grid[F_EY][c],
				coef[C_E_GAIN_X], diff(grid[F_HZ][c], grid[F_HZ][px]),
				coef[C_E_GAIN_Z], diff(grid[F_HX][pz], grid[F_HX][c]));
			grid[F_EZ][c] = mac3(coef[C_E_DECAY], grid[F_EZ][c],
				coef[C_E_GAIN_X], diff(grid[F_HY][px], grid[F_HY][c]),
				coef[C_E_GAIN_Y], diff(grid[F_HX][c], grid[F_HX][py]));
		end
		for (int i = 0; i < CELLS; i++) begin
			{x, y, z} = i[11:0];
			c  = i;
			mx = cell_of(x - 4'd1, y, z);
			my = cell_of(x, y - 4'd1, z);
			mz = cell_of(x, y, z - 4'd1);
			grid[F_HX][c] = mac3(coef[C_H_DECAY], grid[F_HX][c],
				coef[C_H_GAIN_Y], diff(grid[F_EZ][my], grid[F_EZ][c]),
				coef[C_H_GAIN_Z], diff(grid[F_EY][c], grid[F_EY][mz]));
			grid[F_HY][c] = mac3(coef[C_H_DECAY], grid[F_HY][c],
				coef[C_H_GAIN_X], diff(grid[F_EZ][c], grid[F_EZ][mx]),
				coef[C_H_GAIN_Z], diff(grid[F_EX][mz], grid[F_EX][c]));
			grid[F_HZ][c] = mac3(coef[C_H_DECAY], grid[F_HZ][c],
				coef[C_H_GAIN_X], diff(grid[F_EY][mx], grid[F_EY][c]),
				coef[C_H_GAIN_Y], diff(grid[F_EX][c], grid[F_EX][my]));
		end
	endtask

	task automatic predict_word();
		result_t r;
		int c;
		foreach (r.f[i]) r.f[i] = '0;
		r.sat = 1'b0;
		c = cell_of(in_ch.cell_x, in_ch.cell_y, in_ch.cell_z);
		case (cmd_t'(in_ch.cmd))
			CMD_WRITE: begin
				grid[F_EX][c] = in_ch.in_ex;
				grid[F_EY][c] = in_ch.in_ey;
				grid[F_EZ][c] = in_ch.in_ez;
				grid[F_HX][c] = in_ch.in_hx;
				grid[F_HY][c] = in_ch.in_hy;
				grid[F_HZ][c] = in_ch.in_hz;
			end
			CMD_READ: begin
				foreach (r.f[i]) r.f[i] = grid[i][c];
			end
			CMD_STEP: begin
				advance_fields();
				r.sat = step_sat;
			end
			default: ;
		endcase
		expected_words.push_back(r);
	endtask

	task automatic check_word();
		result_t e;
		field_t got[NUM_FIELDS];
		logic bad;
		if (expected_words.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result word with none expected", $time);
			return;
		end
		e = expected_words.pop_front();
		got = '{out_ch.out_ex, out_ch.out_ey, out_ch.out_ez,
			out_ch.out_hx, out_ch.out_hy, out_ch.out_hz};
		bad = (out_ch.saturated !== e.sat);
		foreach (got[i]) if (got[i] !== e.f[i]) bad = 1'b1;
		if (bad) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: word mismatch", $time);
				foreach (got[i])
					$display("  field %0d exp %h got %h", i, e.f[i], got[i]);
				$display("  saturated exp %b got %b", e.sat, out_ch.saturated);
			end
		end
	endtask

	initial begin
		fail_count = 0;
		foreach (grid[f, c]) grid[f][c] = '0;
		foreach (coef[i]) coef[i] = COEF_RESET;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we && cfg_index < NUM_COEF)
				coef[cfg_index[2:0]] = cfg_data;
			if (in_ch.valid && in_ch.ready)
				predict_word();
			if (out_ch.valid && out_ch.ready)
				check_word();
		end
		words_pending = expected_words.size();
	end

	initial words_pending = 0;

	final begin
	end
endmodule
`default_nettype wire

FILE: dv/tb_periodic_yee_field_stepper.sv
// Testbench top for the periodic Yee field stepper: stimulus, handshakes and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_periodic_yee_field_stepper;
	import pys_pkg::*;

	localparam int CYCLE_LIMIT = 2_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;
	int                   words_pending;
	int                   fail_count;
	int                   cycles;
	int                   words_taken;
	bit                   no_idle;

	pys_in_if  in_ch();
	pys_out_if out_ch();

	periodic_yee_field_stepper #(.GRID_SIDE(16)) i_dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	pys_tb_checker i_checker (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.words_pending(words_pending), .fail_count(fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		int stall;
		bit held;
		out_ch.ready = 1'b0;
		words_taken = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 16);
			if (!held && words_taken == 30) begin
				stall = 400;
				held = 1'b1;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
			words_taken++;
		end
	end

	task automatic send_word(cmd_t cmd, logic [3:0] x, logic [3:0] y, logic [3:0] z,
		field_t ex, field_t ey, field_t ez, field_t hx, field_t hy, field_t hz);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 16);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid  <= 1'b1;
		in_ch.cmd    <= cmd;
		in_ch.cell_x <= x;
		in_ch.cell_y <= y;
		in_ch.cell_z <= z;
		in_ch.in_ex  <= ex;
		in_ch.in_ey  <= ey;
		in_ch.in_ez  <= ez;
		in_ch.in_hx  <= hx;
		in_ch.in_hy  <= hy;
		in_ch.in_hz  <= hz;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
	endtask

	task automatic send_random_write();
		field_t v[NUM_FIELDS];
		foreach (v[i])
			v[i] = ($urandom_range(0, 3) == 0) ? field_t'($urandom) :
				field_t'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
		send_word(CMD_WRITE, 4'($urandom), 4'($urandom), 4'($urandom),
			v[0], v[1], v[2], v[3], v[4], v[5]);
	endtask

	task automatic send_read(logic [3:0] x, logic [3:0] y, logic [3:0] z);
		send_word(CMD_READ, x, y, z, field_t'($urandom), field_t'($urandom),
			field_t'($urandom), field_t'($urandom), field_t'($urandom), field_t'($urandom));
	endtask

	// coefficients change only with nothing in flight
	task automatic load_coefs(coef_t c[NUM_COEF]);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		for (int i = 0; i < NUM_COEF; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= c[i];
			@(posedge clk);
		end
		// unused index must leave everything alone
		cfg_index <= CFG_IDX_W'(NUM_COEF + $urandom_range(0, 7));
		cfg_data  <= COEF_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		coef_t c[NUM_COEF];
		int steps_left;
		int r;
		arst_n       = 1'b0;
		no_idle      = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_ch.valid  = 1'b0;
		in_ch.cmd    = CMD_NONE;
		in_ch.cell_x = '0;
		in_ch.cell_y = '0;
		in_ch.cell_z = '0;
		in_ch.in_ex  = '0;
		in_ch.in_ey  = '0;
		in_ch.in_ez  = '0;
		in_ch.in_hx  = '0;
		in_ch.in_hy  = '0;
		in_ch.in_hz  = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every command, unwritten cell
		send_read(4'd3, 4'd4, 4'd5);
		send_word(CMD_WRITE, 4'd0, 4'd0, 4'd0, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_word(CMD_WRITE, 4'd15, 4'd15, 4'd15, 32'sh8000_0000, 32'sh7fff_ffff,
			32'sh0000_0000, 32'shffff_ffff, 32'sh0001_0000, 32'sh7fff_ffff);
		send_word(CMD_WRITE, 4'd15, 4'd0, 4'd7, 32'sh5555_5555, 32'shaaaa_aaaa,
			32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555, 32'shaaaa_aaaa);
		send_word(CMD_WRITE, 4'd1, 4'd2, 4'd3, 32'sh0000_8000, 32'shffff_8000,
			32'sh0001_8000, 32'shfffe_8000, 32'sh0000_0001, 32'shffff_ffff);
		send_read(4'd0, 4'd0, 4'd0);
		send_read(4'd15, 4'd15, 4'd15);
		send_read(4'd15, 4'd0, 4'd7);
		send_word(CMD_NONE, 4'd1, 4'd2, 4'd3, '1, '1, '1, '1, '1, '1);
		send_read(4'd1, 4'd2, 4'd3);
		send_word(CMD_STEP, 4'd0, 4'd0, 4'd0, '0, '0, '0, '0, '0, '0);
		send_read(4'd0, 4'd0, 4'd0);
		send_read(4'd15, 4'd15, 4'd15);
		send_read(4'd0, 4'd15, 4'd0);
		send_read(4'd1, 4'd2, 4'd3);

		// settings: extremes, zeros, swapped extremes, then random
		for (int ph = 0; ph < 4; ph++) begin
			foreach (c[i])
				case (ph)
					0: c[i] = (i % 2) ? 18'sh1ffff : 18'sh20000;
					1: c[i] = '0;
					2: c[i] = (i % 2) ? 18'sh20000 : 18'sh1ffff;
					default: c[i] = coef_t'($urandom);
				endcase
			load_coefs(c);
			steps_left = 2;
			for (int n = 0; n < 25; n++) begin
				no_idle = (n >= 10 && n < 16);
				r = $urandom_range(0, 99);
				if (r < 4 && steps_left > 0) begin
					steps_left--;
					send_word(CMD_STEP, 4'($urandom), 4'($urandom), 4'($urandom),
						field_t'($urandom), field_t'($urandom), field_t'($urandom),
						field_t'($urandom), field_t'($urandom), field_t'($urandom));
				end else if (r < 50) begin
					send_random_write();
				end else if (r < 95) begin
					send_read(4'($urandom), 4'($urandom), 4'($urandom));
				end else begin
					send_word(CMD_NONE, 4'($urandom), 4'($urandom), 4'($urandom),
						field_t'($urandom), field_t'($urandom), field_t'($urandom),
						field_t'($urandom), field_t'($urandom), field_t'($urandom));
				end
			end
			if (steps_left == 2)
				send_word(CMD_STEP, '0, '0, '0, '0, '0, '0, '0, '0, '0);
			no_idle = 1'b0;
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (words_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
hdl/pys_pkg.sv
hdl/pys_if.sv
hdl/pys_ctrl.sv
hdl/pys_dp.sv
hdl/periodic_yee_field_stepper.sv
hdl/pys_checker.sv
dv/pys_tb_checker.sv
dv/tb_periodic_yee_field_stepper.sv
